/* sv/brace_match_scanner_core_assert.svh */
// Assertion macros for the brace match scanner checker.
`ifndef BRACE_MATCH_SCANNER_CORE_ASSERT_SVH
`define BRACE_MATCH_SCANNER_CORE_ASSERT_SVH

// Assertion sampled on the rising clock edge, active through reset.
`define BMS_ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

// Assertion sampled on the rising clock edge, disabled while reset is high.
`define BMS_ASSERT_RUN(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

/* sv/bms_pkg.sv */
// Types, character codes, lexical modes and status codes for the brace match scanner.
package bms_pkg;

   // Default widths of the depth counter and the offset counter
   localparam int DEPTH_BITS_DEF  = 8;
   localparam int OFFSET_BITS_DEF = 16;

   // Fixed field widths
   localparam int CH_W     = 8;
   localparam int STATUS_W = 3;
   localparam int MATCH_W  = 16;
   localparam int MODE_W   = 3;

   // Characters the lexer reacts to
   localparam logic [CH_W-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CH_W-1:0] CH_RBRACE = 8'h7D;
   localparam logic [CH_W-1:0] CH_NL     = 8'h0A;
   localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;

   // Lexical modes
   localparam logic [MODE_W-1:0] MODE_CODE  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SLASH = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LINE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BLOCK = 3'd3;
   localparam logic [MODE_W-1:0] MODE_STAR  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_LIT   = 3'd5;
   localparam logic [MODE_W-1:0] MODE_ESC   = 3'd6;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_BRACE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNTERM    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DEPTH     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_LONG      = 3'd5;

   // Lexer state carried from byte to byte
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              quote_single;
   } lex_state_type;

   // One result as produced by the step logic
   typedef struct packed {
      logic                hit;
      logic [STATUS_W-1:0] status;
      logic [MATCH_W-1:0]  match_offset;
   } step_result_type;

endpackage

/* sv/bms_step.sv */
// Next-state and result logic for one byte of the brace match scanner.
module bms_step
   import bms_pkg::*;
#(
   parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic [CH_W-1:0]        ch,
   input  logic                   start_req,
   input  logic                   last,
   input  lex_state_type          lex_cur,
   input  logic                   active_cur,
   input  logic [DEPTH_BITS-1:0]  depth_cur,
   input  logic [OFFSET_BITS-1:0] offset_cur,
   output lex_state_type          lex_nx,
   output logic                   active_nx,
   output logic [DEPTH_BITS-1:0]  depth_nx,
   output logic [OFFSET_BITS-1:0] offset_nx,
   output step_result_type        result
);

   logic                          run_code;
   logic                          hit;
   logic [STATUS_W-1:0]           status;
   logic [CH_W-1:0]               close_quote;
   logic [OFFSET_BITS+MATCH_W-1:0] offset_ext;

   assign close_quote = lex_cur.quote_single ? CH_SQUOTE : CH_DQUOTE;

   // Lexer mode transition, brace counting and end-of-search detection
   always_comb begin
      lex_nx    = lex_cur;
      active_nx = active_cur;
      depth_nx  = depth_cur;
      offset_nx = offset_cur;
      hit       = 1'b0;
      status    = ST_FOUND;
      run_code  = 1'b0;

      if (start_req) begin
         lex_nx.mode         = MODE_CODE;
         lex_nx.quote_single = 1'b0;
         offset_nx           = '0;
         if (ch != CH_LBRACE) begin
            depth_nx  = '0;
            active_nx = 1'b0;
            hit       = 1'b1;
            status    = ST_NOT_BRACE;
         end else begin
            depth_nx  = DEPTH_BITS'(1);
            active_nx = 1'b1;
            if (last) begin
               hit    = 1'b1;
               status = ST_UNMATCHED;
            end
         end
      end else if (active_cur) begin
         if (&offset_cur) begin
            hit    = 1'b1;
            status = ST_LONG;
         end else begin
            offset_nx = offset_cur + 1'b1;

            // comment and literal tracking
            case (lex_cur.mode)
               MODE_SLASH: begin
                  if (ch == CH_SLASH) begin
                     lex_nx.mode = MODE_LINE;
                  end else if (ch == CH_STAR) begin
                     lex_nx.mode = MODE_BLOCK;
                  end else begin
                     lex_nx.mode = MODE_CODE;
                     run_code    = 1'b1;
                  end
               end
               MODE_LINE: begin
                  if (ch == CH_NL) lex_nx.mode = MODE_CODE;
               end
               MODE_BLOCK: begin
                  if (ch == CH_STAR) lex_nx.mode = MODE_STAR;
               end
               MODE_STAR: begin
                  if (ch == CH_SLASH) begin
                     lex_nx.mode = MODE_CODE;
                  end else if (ch != CH_STAR) begin
                     lex_nx.mode = MODE_BLOCK;
                  end
               end
               MODE_LIT: begin
                  if (ch == CH_BSLASH) begin
                     lex_nx.mode = MODE_ESC;
                  end else if (ch == close_quote) begin
                     lex_nx.mode = MODE_CODE;
                  end
               end
               MODE_ESC: begin
                  lex_nx.mode = MODE_LIT;
               end
               default: begin
                  lex_nx.mode = MODE_CODE;
                  run_code    = 1'b1;
               end
            endcase

            // code byte: braces, comment openers and quotes
            if (run_code) begin
               if (ch == CH_LBRACE) begin
                  if (&depth_cur) begin
                     hit    = 1'b1;
                     status = ST_DEPTH;
                  end else begin
                     depth_nx = depth_cur + 1'b1;
                  end
               end else if (ch == CH_RBRACE) begin
                  depth_nx = depth_cur - 1'b1;
                  if (depth_cur == DEPTH_BITS'(1)) begin
                     hit    = 1'b1;
                     status = ST_FOUND;
                  end
               end else if (ch == CH_SLASH) begin
                  lex_nx.mode = MODE_SLASH;
               end else if (ch == CH_DQUOTE) begin
                  lex_nx.mode         = MODE_LIT;
                  lex_nx.quote_single = 1'b0;
               end else if (ch == CH_SQUOTE) begin
                  lex_nx.mode         = MODE_LIT;
                  lex_nx.quote_single = 1'b1;
               end
            end

            // end of text without a match
            if (!hit && last) begin
               hit    = 1'b1;
               status = (lex_nx.mode inside {MODE_LIT, MODE_ESC}) ? ST_UNTERM : ST_UNMATCHED;
            end
         end
      end

      if (hit) active_nx = 1'b0;
   end

   // Offset is reported in its low bits, zero unless found
   assign offset_ext          = {{MATCH_W{1'b0}}, offset_nx};
   assign result.hit          = hit;
   assign result.status       = status;
   assign result.match_offset = (status == ST_FOUND) ? offset_ext[MATCH_W-1:0] : '0;

endmodule

/* sv/brace_match_scanner_core.sv */
// Top level of the brace match scanner: input register, lexer state and result register.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_ch, req_start_req, req_last
//   rsp     | out       | rsp_valid/rsp_stall | rsp_status, rsp_match_offset
//
// One byte is taken per cycle while the result is not stalled. A byte is held
// in the input register and its result in the result register. The rate is set
// by the update of lexer mode, brace depth and offset counter from the input register.
// Synchronous reset clears both stages, the search flag and the lexer state.
// A stalled result holds the byte in the input register, and req_stall rises.
module brace_match_scanner_core
   import bms_pkg::*;
#(
   parameter int DEPTH_BITS  = DEPTH_BITS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CH_W-1:0]     req_ch,
   input  logic                req_start_req,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [MATCH_W-1:0]  rsp_match_offset
);

   // input register
   logic                   in_vld_ff, in_vld_in;
   logic [CH_W-1:0]        in_ch_ff;
   logic                   in_start_ff;
   logic                   in_last_ff;

   // scan state
   lex_state_type          lex_ff, lex_in;
   logic                   active_ff, active_in;
   logic [DEPTH_BITS-1:0]  depth_ff, depth_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;

   // result register
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [MATCH_W-1:0]     rsp_offset_ff;

   step_result_type        step_res;
   logic                   proceed;
   logic                   req_xfer;

   // The held byte moves on when the result register is free or being taken
   assign proceed   = in_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !proceed;
   assign req_xfer  = req_valid && !req_stall;

   bms_step #(
      .DEPTH_BITS  (DEPTH_BITS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_step (
      .ch         (in_ch_ff),
      .start_req  (in_start_ff),
      .last       (in_last_ff),
      .lex_cur    (lex_ff),
      .active_cur (active_ff),
      .depth_cur  (depth_ff),
      .offset_cur (offset_ff),
      .lex_nx     (lex_in),
      .active_nx  (active_in),
      .depth_nx   (depth_in),
      .offset_nx  (offset_in),
      .result     (step_res)
   );

   assign in_vld_in  = req_xfer || (in_vld_ff && !proceed);
   assign rsp_vld_in = proceed ? step_res.hit : (rsp_vld_ff && rsp_stall);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_xfer) begin
         in_ch_ff    <= req_ch;
         in_start_ff <= req_start_req;
         in_last_ff  <= req_last;
      end
   end

   // Scan state, advanced once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff.mode         <= MODE_CODE;
         lex_ff.quote_single <= 1'b0;
         active_ff           <= 1'b0;
         depth_ff            <= '0;
         offset_ff           <= '0;
      end else if (proceed) begin
         lex_ff    <= lex_in;
         active_ff <= active_in;
         depth_ff  <= depth_in;
         offset_ff <= offset_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      if (proceed && step_res.hit) begin
         rsp_status_ff <= step_res.status;
         rsp_offset_ff <= step_res.match_offset;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_match_offset = rsp_offset_ff;

endmodule

/* sv/bms_checker.sv */
// Port-level checker for the brace match scanner, bound to the top level.
`include "brace_match_scanner_core_assert.svh"

module bms_checker
   import bms_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [MATCH_W-1:0]  rsp_match_offset
);

   // no result survives reset
   `BMS_ASSERT_CLK(a_reset_clears_rsp, reset |=> !rsp_valid, "result valid after reset")

   // a stalled result holds
   `BMS_ASSERT_RUN(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_match_offset), "stalled result changed")

   // only defined status codes are reported
   `BMS_ASSERT_RUN(a_status_legal, rsp_valid |-> rsp_status <= ST_LONG, "undefined status code")

   // offset is zero unless a match was found
   `BMS_ASSERT_RUN(a_offset_zero, rsp_valid && rsp_status != ST_FOUND |-> rsp_match_offset == '0, "offset set on error status")

   // an empty result register never holds back the input
   `BMS_ASSERT_RUN(a_no_false_stall, !rsp_valid |-> !req_stall, "input stalled with no result pending")

endmodule

bind brace_match_scanner_core bms_checker u_bms_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_match_offset (rsp_match_offset)
);
